// File: hdl/brace_quote_list_splitter_macros.svh
// Assertion macros for the brace/quote list splitter checker.
// Expects signals named clock and reset in the scope of use.
`ifndef BRACE_QUOTE_LIST_SPLITTER_MACROS_SVH
`define BRACE_QUOTE_LIST_SPLITTER_MACROS_SVH

// same-cycle implication, off while reset is high
`define BQLS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bqls assertion failed");

// next-cycle implication, off while reset is high
`define BQLS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bqls assertion failed");

// next-cycle implication, checked through reset as well
`define BQLS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bqls assertion failed");

`endif

// File: hdl/bqls_pkg.sv
// Package for the brace/quote list splitter: limits, character codes,
// parser phase and status enums, and the structs passed between modules.
package bqls_pkg;

   localparam int MAX_DEPTH    = 255;
   localparam int MAX_ELEMENTS = 1024;

   // nesting and numbering limits, capped by the 8-bit and 10-bit fields
   localparam logic [7:0] DEPTH_CAP = 8'((MAX_DEPTH > 255) ? 255 : MAX_DEPTH);
   localparam logic [9:0] COUNT_CAP =
      10'((MAX_ELEMENTS - 1 > 1023) ? 1023 : MAX_ELEMENTS - 1);

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef enum logic [2:0] {
      PH_SKIP        = 3'd0,
      PH_BARE        = 3'd1,
      PH_BRACE       = 3'd2,
      PH_QUOTE       = 3'd3,
      PH_AFTER_BRACE = 3'd4,
      PH_AFTER_QUOTE = 3'd5,
      PH_ERROR       = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_AFTER_BRACE = 3'd1,
      ST_AFTER_QUOTE = 3'd2,
      ST_OPEN_BRACE  = 3'd3,
      ST_OPEN_QUOTE  = 3'd4,
      ST_TOO_DEEP    = 3'd5
   } status_type;

   typedef struct packed {
      logic blank;
      logic open_brace;
      logic close_brace;
      logic quote;
   } class_type;

   typedef struct packed {
      logic       content_valid;
      logic [7:0] content_byte;
      logic       element_done;
      logic       element_braced;
      logic [9:0] element_number;
      status_type status;
      logic       list_done;
   } result_type;

endpackage

// File: hdl/bqls_req_if.sv
// Input channel of the list splitter: one text byte per item.
// Standalone; no package needed.
interface bqls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_char;

   modport source  (output valid, char_in, last_char, input ready);
   modport sink    (input valid, char_in, last_char, output ready);
   modport monitor (input valid, ready, char_in, last_char);
endinterface

// File: hdl/bqls_rsp_if.sv
// Result channel of the list splitter: one result per text byte.
// Standalone; no package needed.
interface bqls_rsp_if;
   logic       valid;
   logic       ready;
   logic       content_valid;
   logic [7:0] content_byte;
   logic       element_done;
   logic       element_braced;
   logic [9:0] element_number;
   logic [2:0] status;
   logic       list_done;

   modport source (output valid, content_valid, content_byte, element_done,
                   element_braced, element_number, status, list_done,
                   input ready);
   modport sink   (input valid, content_valid, content_byte, element_done,
                   element_braced, element_number, status, list_done,
                   output ready);
   modport monitor (input valid, ready, content_valid, content_byte, element_done,
                    element_braced, element_number, status, list_done);
endinterface

// File: hdl/bqls_char_class.sv
// Byte classifier: white space, braces and quote.
// Uses bqls_pkg.
module bqls_char_class (
   input  logic [7:0]          char_in,
   output bqls_pkg::class_type cls
);
   import bqls_pkg::*;

   always_comb begin
      cls.blank       = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
      cls.open_brace  = (char_in == CH_LBRACE);
      cls.close_brace = (char_in == CH_RBRACE);
      cls.quote       = (char_in == CH_QUOTE);
   end
endmodule

// File: hdl/bqls_parse_fsm.sv
// Parser state (phase, depth, element count, sticky error) and per-byte result.
// Uses bqls_pkg; fed by bqls_char_class.
module bqls_parse_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           char_in,
   input  logic                 last_char,
   input  bqls_pkg::class_type  cls,
   output bqls_pkg::result_type result
);
   import bqls_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] depth_ff, depth_in;
   logic [9:0] count_ff, count_in;
   status_type err_ff, err_in;

   status_type err_new;
   logic [9:0] count_bump;

   assign count_bump = (count_ff < COUNT_CAP) ? count_ff + 10'd1 : count_ff;

   // error raised (or held) by this byte
   always_comb begin
      err_new = err_ff;
      if (err_ff == ST_OK) begin
         case (phase_ff)
            PH_BRACE: begin
               if (cls.open_brace && depth_ff >= DEPTH_CAP)
                  err_new = ST_TOO_DEEP;
               else if (last_char && !(cls.close_brace && depth_ff <= 8'd1))
                  err_new = ST_OPEN_BRACE;
            end
            PH_QUOTE: begin
               if (last_char && !cls.quote) err_new = ST_OPEN_QUOTE;
            end
            PH_AFTER_BRACE: begin
               if (!cls.blank) err_new = ST_AFTER_BRACE;
            end
            PH_AFTER_QUOTE: begin
               if (!cls.blank) err_new = ST_AFTER_QUOTE;
            end
            PH_BARE: begin
               err_new = ST_OK;
            end
            default: begin
               // skip phase: a list that ends on an opener is left open
               if (last_char && cls.open_brace) err_new = ST_OPEN_BRACE;
               else if (last_char && cls.quote) err_new = ST_OPEN_QUOTE;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      depth_in = depth_ff;
      count_in = count_ff;
      err_in   = err_ff;
      if (last_char) begin
         phase_in = PH_SKIP;
         depth_in = '0;
         count_in = '0;
         err_in   = ST_OK;
      end else if (err_new != ST_OK) begin
         phase_in = PH_ERROR;
         err_in   = err_new;
      end else begin
         case (phase_ff)
            PH_BARE: begin
               if (cls.blank) begin
                  phase_in = PH_SKIP;
                  count_in = count_bump;
               end
            end
            PH_BRACE: begin
               if (cls.open_brace) begin
                  depth_in = depth_ff + 8'd1;
               end else if (cls.close_brace) begin
                  if (depth_ff > 8'd1) begin
                     depth_in = depth_ff - 8'd1;
                  end else begin
                     depth_in = '0;
                     phase_in = PH_AFTER_BRACE;
                     count_in = count_bump;
                  end
               end
            end
            PH_QUOTE: begin
               if (cls.quote) begin
                  phase_in = PH_AFTER_QUOTE;
                  count_in = count_bump;
               end
            end
            PH_AFTER_BRACE, PH_AFTER_QUOTE: begin
               if (cls.blank) phase_in = PH_SKIP;
            end
            default: begin
               if (cls.blank) begin
                  phase_in = PH_SKIP;
               end else if (cls.open_brace) begin
                  depth_in = 8'd1;
                  phase_in = PH_BRACE;
               end else if (cls.quote) begin
                  phase_in = PH_QUOTE;
               end else begin
                  phase_in = PH_BARE;
               end
            end
         endcase
      end
   end

   // result for this byte
   always_comb begin
      logic cur;
      cur = 1'b0;
      result.content_valid  = 1'b0;
      result.element_done   = 1'b0;
      result.element_braced = 1'b0;
      case (phase_ff)
         PH_BARE: begin
            cur = 1'b1;
            result.element_done  = cls.blank || last_char;
            result.content_valid = !cls.blank;
         end
         PH_BRACE: begin
            cur = 1'b1;
            result.element_braced = 1'b1;
            if (cls.close_brace && depth_ff <= 8'd1) result.element_done = 1'b1;
            else result.content_valid = 1'b1;
         end
         PH_QUOTE: begin
            cur = 1'b1;
            if (cls.quote) result.element_done = 1'b1;
            else result.content_valid = 1'b1;
         end
         PH_AFTER_BRACE, PH_AFTER_QUOTE: begin
            cur = 1'b0;
         end
         default: begin
            if (!cls.blank) begin
               cur = 1'b1;
               if (cls.open_brace) begin
                  result.element_braced = 1'b1;
               end else if (!cls.quote) begin
                  result.content_valid = 1'b1;
                  result.element_done  = last_char;
               end
            end
         end
      endcase
      result.element_number = cur ? count_ff : '0;
      if (err_new != ST_OK) begin
         result.content_valid  = 1'b0;
         result.element_done   = 1'b0;
         result.element_braced = 1'b0;
         result.element_number = '0;
      end
      result.content_byte = result.content_valid ? char_in : '0;
      result.status       = err_new;
      result.list_done    = last_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         depth_ff <= '0;
         count_ff <= '0;
         err_ff   <= ST_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end
endmodule

// File: hdl/brace_quote_list_splitter.sv
// Brace/quote list splitter, top level.
// Uses bqls_pkg, bqls_req_if, bqls_rsp_if, bqls_char_class, bqls_parse_fsm.
//
// Usage:
//   req_chan carries one byte of list text per item (char_in) and a flag
//   (last_char) that marks the final byte of a list. rsp_chan returns one
//   result item per byte: content byte and flag, element done/braced,
//   element number, status code and list_done.
//   Both channels use valid/ready; an item moves on a rising edge with
//   valid and ready high.
//   An accepted item passes the input register, then the result register,
//   before its result shows on rsp_chan. Throughput: one item per cycle
//   while rsp_chan is not stalled, set by the single parser state update per item.
//   A stalled receiver holds the result register; the input register still
//   takes one more item, and req_chan.ready drops only while both are full.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to skipping white space at the start of a new list. The final
//   byte of each list also returns the parser to that state.
module brace_quote_list_splitter (
   input  logic      clock,
   input  logic      reset,
   bqls_req_if.sink  req_chan,
   bqls_rsp_if.source rsp_chan
);
   import bqls_pkg::*;

   // input register
   logic       in_v_ff, in_v_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // result register
   logic       out_v_ff, out_v_in;
   result_type out_ff;

   logic       advance;
   logic       req_take;
   class_type  cls;
   result_type result;

   // an item moves from input to result register when the result slot frees
   assign advance  = in_v_ff && (!out_v_ff || rsp_chan.ready);
   assign req_chan.ready = !in_v_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_v_in  = req_take || (in_v_ff && !advance);
   assign out_v_in = advance || (out_v_ff && !rsp_chan.ready);

   bqls_char_class u_class (
      .char_in (in_char_ff),
      .cls     (cls)
   );

   bqls_parse_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_in   (in_char_ff),
      .last_char (in_last_ff),
      .cls       (cls),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_in;
         in_last_ff <= req_chan.last_char;
      end
      if (advance) out_ff <= result;
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.content_valid  = out_ff.content_valid;
   assign rsp_chan.content_byte   = out_ff.content_byte;
   assign rsp_chan.element_done   = out_ff.element_done;
   assign rsp_chan.element_braced = out_ff.element_braced;
   assign rsp_chan.element_number = out_ff.element_number;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.list_done      = out_ff.list_done;
endmodule

// File: hdl/bqls_checker.sv
// Port-level checks for the list splitter, bound to the top level.
// Uses brace_quote_list_splitter_macros.svh, bqls_req_if, bqls_rsp_if.
`include "brace_quote_list_splitter_macros.svh"

module bqls_checker (
   input logic        clock,
   input logic        reset,
   bqls_req_if.sink   req_chan,
   bqls_rsp_if.source rsp_chan
);
   // a stalled result holds
   `BQLS_ASSERT_NEXT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable({rsp_chan.content_valid, rsp_chan.content_byte, rsp_chan.element_done, rsp_chan.element_braced, rsp_chan.element_number, rsp_chan.status, rsp_chan.list_done}))

   // reset empties the result register
   `BQLS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_chan.valid)

   // input backpressure only while the result side is full and stalled
   `BQLS_ASSERT_IMPL(a_ready_low, !req_chan.ready, rsp_chan.valid && !rsp_chan.ready)

   // a fresh result follows an item accepted through the input and result registers
   `BQLS_ASSERT_IMPL(a_rise_latency, $rose(rsp_chan.valid), $past(req_chan.valid && req_chan.ready, 2))
endmodule

bind brace_quote_list_splitter bqls_checker u_bqls_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for brace_quote_list_splitter: feeds list text byte by byte and checks each
// result against a list parser kept in this file. Depends on bqls_pkg, bqls_req_if,
// bqls_rsp_if and the block itself.
module tb;
   import bqls_pkg::*;

   // character codes not in the package
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_Q   = 8'h71;
   localparam logic [7:0] CH_A   = 8'h61;
   localparam logic [7:0] CH_Z   = 8'h7A;

   localparam int HOLD_OFF_CYCLES    = 150;   // receiver stall in the pressure test
   localparam int STALL_LIMIT        = 2000;  // quiet cycles before the run is abandoned
   localparam int DRAIN_CYCLES       = 8;     // settling wait before the final check
   localparam int RANDOM_ITEMS       = 650;
   localparam int LONG_LIST_ELEMENTS = 200;   // gap-free stretch of one-letter elements
   localparam int MAX_REPORTS        = 10;
   localparam int IDLE_PERCENT       = 22;

   logic clock;
   logic reset;

   bqls_req_if req_chan ();
   bqls_rsp_if rsp_chan ();

   brace_quote_list_splitter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // parser state mirrored here
   phase_type  cur_phase;
   logic [7:0] nest_level;
   logic [9:0] element_idx;
   status_type sticky_status;

   result_type expected_results[$];   // one entry per accepted byte, oldest first
   logic [7:0] list_text[$];          // list being assembled for sending

   bit idle_enable  = 1'b1;           // random gaps on both channels
   int hold_request = 0;              // set by a test, taken by the receiver
   int hold_left    = 0;
   int mismatch_count = 0;
   int result_count   = 0;

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Parser mirror
   // ------------------------------------------------------------------
   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void restart_list();
      cur_phase     = PH_SKIP;
      nest_level    = '0;
      element_idx   = '0;
      sticky_status = ST_OK;
   endfunction

   // numbering saturates, never wraps
   function automatic void close_element();
      if (element_idx < COUNT_CAP)
         element_idx++;
   endfunction

   // One text byte in, the result it should produce out; advances the mirror.
   function automatic result_type split_byte(input logic [7:0] c, input logic last);
      result_type r;
      status_type st;
      logic       ws;
      r  = '0;
      ws = is_blank(c);
      st = sticky_status;
      if (st == ST_OK) begin
         case (cur_phase)
            PH_BARE: begin
               r.element_number = element_idx;
               if (ws) begin
                  r.element_done = 1'b1;
                  close_element();
                  cur_phase = PH_SKIP;
               end else begin
                  r.content_valid = 1'b1;
               end
            end
            PH_BRACE: begin
               r.element_number = element_idx;
               r.element_braced = 1'b1;
               if (c == CH_LBRACE) begin
                  if (nest_level >= DEPTH_CAP) begin
                     st = ST_TOO_DEEP;
                  end else begin
                     nest_level++;
                     r.content_valid = 1'b1;
                  end
               end else if (c == CH_RBRACE) begin
                  if (nest_level > 8'd1) begin
                     nest_level--;
                     r.content_valid = 1'b1;
                  end else begin
                     // outermost close ends the element; brace itself is not content
                     r.element_done = 1'b1;
                     close_element();
                     nest_level = '0;
                     cur_phase  = PH_AFTER_BRACE;
                  end
               end else begin
                  r.content_valid = 1'b1;
               end
            end
            PH_QUOTE: begin
               r.element_number = element_idx;
               if (c == CH_QUOTE) begin
                  r.element_done = 1'b1;
                  close_element();
                  cur_phase = PH_AFTER_QUOTE;
               end else begin
                  r.content_valid = 1'b1;
               end
            end
            PH_AFTER_BRACE: begin
               if (ws) cur_phase = PH_SKIP;
               else st = ST_AFTER_BRACE;
            end
            PH_AFTER_QUOTE: begin
               if (ws) cur_phase = PH_SKIP;
               else st = ST_AFTER_QUOTE;
            end
            default: begin
               // skipping white space; the first other byte opens an element
               if (ws) begin
                  cur_phase = PH_SKIP;
               end else if (c == CH_LBRACE) begin
                  r.element_number = element_idx;
                  r.element_braced = 1'b1;
                  nest_level = 8'd1;
                  cur_phase  = PH_BRACE;
               end else if (c == CH_QUOTE) begin
                  r.element_number = element_idx;
                  cur_phase = PH_QUOTE;
               end else begin
                  r.element_number = element_idx;
                  r.content_valid  = 1'b1;
                  cur_phase = PH_BARE;
               end
            end
         endcase
         // end of list: bare element completes, open brace/quote is an error
         if (st == ST_OK && last) begin
            if (cur_phase == PH_BARE) begin
               r.element_done = 1'b1;
               close_element();
            end else if (cur_phase == PH_BRACE) begin
               st = ST_OPEN_BRACE;
            end else if (cur_phase == PH_QUOTE) begin
               st = ST_OPEN_QUOTE;
            end
         end
      end
      // errors are sticky and blank every other field until the list ends
      if (st != ST_OK) begin
         r = '0;
         sticky_status = st;
         cur_phase = PH_ERROR;
      end
      r.content_byte = r.content_valid ? c : CH_NUL;
      r.status       = st;
      r.list_done    = last;
      if (last)
         restart_list();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Checking: push a prediction per accepted byte, compare per accepted result
   // ------------------------------------------------------------------
   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.content_valid  = rsp_chan.content_valid;
         got.content_byte   = rsp_chan.content_byte;
         got.element_done   = rsp_chan.element_done;
         got.element_braced = rsp_chan.element_braced;
         got.element_number = rsp_chan.element_number;
         got.status         = status_type'(rsp_chan.status);
         got.list_done      = rsp_chan.list_done;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing expected", result_count));
         end else begin
            want = expected_results.pop_front();
            if (got.content_valid  !== want.content_valid  ||
                got.content_byte   !== want.content_byte   ||
                got.element_done   !== want.element_done   ||
                got.element_braced !== want.element_braced ||
                got.element_number !== want.element_number ||
                got.status         !== want.status         ||
                got.list_done      !== want.list_done)
               note_failure($sformatf({"result %0d: expected cv=%0b byte=%02h done=%0b ",
                  "braced=%0b num=%0d status=%0d last=%0b, got cv=%0b byte=%02h done=%0b ",
                  "braced=%0b num=%0d status=%0d last=%0b"}, result_count,
                  want.content_valid, want.content_byte, want.element_done,
                  want.element_braced, want.element_number, want.status, want.list_done,
                  got.content_valid, got.content_byte, got.element_done,
                  got.element_braced, got.element_number, got.status, got.list_done));
         end
         result_count++;
      end
      // a byte accepted now cannot have its result out on the same edge
      if (!reset && req_chan.valid && req_chan.ready)
         expected_results.push_back(split_byte(req_chan.char_in, req_chan.last_char));
   end

   // ------------------------------------------------------------------
   // Receiver: random ready, plus a long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_receiver
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Watchdog: abandon the run if nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("brace_quote_list_splitter verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sending
   // ------------------------------------------------------------------
   // Offer one byte, with random gaps first; returns on the accepting edge.
   task automatic send_byte(input logic [7:0] c, input logic last);
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_in   <= c;
      req_chan.last_char <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Send the assembled list, last flag on its final byte.
   task automatic send_list();
      for (int i = 0; i < list_text.size(); i++)
         send_byte(list_text[i], i == list_text.size() - 1);
      list_text.delete();
   endtask

   // Drop valid and wait for every outstanding result.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // List text generation
   // ------------------------------------------------------------------
   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         list_text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] blank_byte();
      if ($urandom_range(5) == 0)
         return CH_SPACE;
      return 8'(CH_TAB + $urandom_range(4));   // tab through carriage return
   endfunction

   function automatic void add_blanks();
      repeat ($urandom_range(1, 3))
         list_text.push_back(blank_byte());
   endfunction

   // random byte other than x and y, optionally also not white space
   function automatic logic [7:0] pick_byte(input logic [7:0] x, input logic [7:0] y,
                                            input bit no_blank);
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == x || c == y || (no_blank && is_blank(c)));
      return c;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(5))
         0: return blank_byte();
         1: return CH_LBRACE;
         2: return CH_RBRACE;
         3: return CH_QUOTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly well-formed lists with random content; some noise, some missing
   // separators and some cut short so the error paths are hit too.
   function automatic void build_random_list();
      int n_elem;
      int len;
      int lvl;
      int pick;
      int cut;
      list_text.delete();
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 24))
            list_text.push_back(noise_byte());
         return;
      end
      if ($urandom_range(3) == 0)
         add_blanks();
      n_elem = $urandom_range(1, 8);
      for (int e = 0; e < n_elem; e++) begin
         // a rare missing separator can give text after a close
         if (e != 0 && $urandom_range(99) >= 4)
            add_blanks();
         len = $urandom_range(0, 6);
         case ($urandom_range(2))
            0: begin
               list_text.push_back(pick_byte(CH_LBRACE, CH_QUOTE, 1'b1));
               repeat (len) list_text.push_back(pick_byte(CH_SPACE, CH_SPACE, 1'b1));
            end
            1: begin
               list_text.push_back(CH_QUOTE);
               repeat (len) list_text.push_back(pick_byte(CH_QUOTE, CH_QUOTE, 1'b0));
               list_text.push_back(CH_QUOTE);
            end
            default: begin
               list_text.push_back(CH_LBRACE);
               lvl = 0;
               repeat (len * 2) begin
                  pick = $urandom_range(9);
                  if (pick < 2 && lvl < 6) begin
                     list_text.push_back(CH_LBRACE);
                     lvl++;
                  end else if (pick < 4 && lvl > 0) begin
                     list_text.push_back(CH_RBRACE);
                     lvl--;
                  end else begin
                     list_text.push_back(pick_byte(CH_LBRACE, CH_RBRACE, 1'b0));
                  end
               end
               repeat (lvl) list_text.push_back(CH_RBRACE);
               list_text.push_back(CH_RBRACE);
            end
         endcase
      end
      if ($urandom_range(1))
         add_blanks();
      // truncated list: may end inside a brace or quote
      if ($urandom_range(99) < 8) begin
         cut = $urandom_range(1, list_text.size());
         while (list_text.size() > cut)
            void'(list_text.pop_back());
      end
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Short lists: nesting, empty quoted element, NUL byte as bare element
   // closed by end of list, text after brace and after quote, open brace
   // and open quote at the end, white space only.
   task automatic test_directed_lists();
      add_text("{a{}} \"\"\t");
      list_text.push_back(CH_NUL);
      send_list();
      add_text("{}xy");
      send_list();
      add_text("\"\"\"");
      send_list();
      list_text.push_back(CH_LBRACE);
      list_text.push_back(8'hFF);
      send_list();
      list_text.push_back(CH_QUOTE);
      list_text.push_back(CH_LF);
      send_list();
      list_text.push_back(CH_VT);
      list_text.push_back(CH_FF);
      list_text.push_back(CH_CR);
      send_list();
   endtask

   // Nest to the cap, step back one, reach it again, then one too many.
   task automatic test_nesting_limit();
      repeat (DEPTH_CAP) list_text.push_back(CH_LBRACE);
      list_text.push_back(CH_RBRACE);
      list_text.push_back(CH_LBRACE);
      list_text.push_back(CH_LBRACE);
      list_text.push_back(CH_Q);
      send_list();
   endtask

   // Receiver stalls for a long stretch while the sender keeps offering,
   // so both registers fill and req ready drops.
   task automatic test_receiver_holdoff();
      hold_request = HOLD_OFF_CYCLES;
      repeat (4) begin
         build_random_list();
         send_list();
      end
      wait_for_results();
   endtask

   // Sender goes quiet after each list until the block has emptied.
   task automatic test_sender_pause();
      repeat (5) begin
         build_random_list();
         send_list();
         wait_for_results();
      end
   endtask

   // One long list of one-letter elements, sent with no gaps on either side.
   task automatic test_long_list();
      idle_enable = 1'b0;
      repeat (LONG_LIST_ELEMENTS) begin
         list_text.push_back(8'($urandom_range(CH_A, CH_Z)));
         list_text.push_back(blank_byte());
      end
      send_list();
      idle_enable = 1'b1;
   endtask

   task automatic test_random_lists();
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         build_random_list();
         sent += list_text.size();
         send_list();
      end
   endtask

   // ------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_in   = '0;
      req_chan.last_char = 1'b0;
      rsp_chan.ready     = 1'b0;
      restart_list();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_lists();
      test_nesting_limit();
      test_receiver_holdoff();
      test_sender_pause();
      test_long_list();
      test_random_lists();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_results.size()));

      if (mismatch_count == 0)
         $display("brace_quote_list_splitter verification clean");
      else
         $display("brace_quote_list_splitter verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/bqls_pkg.sv
hdl/bqls_req_if.sv
hdl/bqls_rsp_if.sv
hdl/bqls_char_class.sv
hdl/bqls_parse_fsm.sv
hdl/brace_quote_list_splitter.sv
hdl/bqls_checker.sv
test/tb.sv
